@@ src/u8u16_pkg.sv @@
package u8u16_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [15:0] HiSurrBase = 16'hD800;
  localparam logic [15:0] LoSurrBase = 16'hDC00;
  localparam logic [20:0] SurrFirst  = 21'h00D800;
  localparam logic [20:0] SurrLast   = 21'h00DFFF;
  localparam logic [20:0] CpMax      = 21'h10FFFF;
  localparam logic [20:0] BmpMax     = 21'h00FFFF;
  localparam logic [20:0] SuppBase   = 21'h010000;

  // register addresses (index into the config map)
  localparam logic RegByteOrder = 1'b0;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_LEAD    = 3'd1,
    ST_ENDED_EARLY = 3'd2,
    ST_INCOMPLETE  = 3'd3,
    ST_OVERLONG    = 3'd4,
    ST_BAD_POINT   = 3'd5
  } status_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        string_done;
    status_t     status;
  } result_t;

  // one queue entry: all results caused by one input byte
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

endpackage

@@ src/u8u16_ifs.sv @@
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] utf8_byte;
  modport source (output valid, output utf8_byte, input ready);
  modport sink (input valid, input utf8_byte, output ready);
endinterface

interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        unit_valid;
  logic        string_done;
  logic [2:0]  status;
  logic        last_of_run;
  modport source (output valid, output code_unit, output unit_valid, output string_done,
                  output status, output last_of_run, input ready);
  modport sink (input valid, input code_unit, input unit_valid, input string_done,
                input status, input last_of_run, output ready);
endinterface

@@ src/u8u16_front.sv @@
module u8u16_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [7:0]           in_byte,
  output logic                 in_ready,
  input  logic                 byte_order,
  input  logic                 q_full,
  output logic                 push,
  output u8u16_pkg::entry_t    push_entry
);
  import u8u16_pkg::*;

  logic [1:0]  bl_r, bl_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [20:0] acc_r, acc_nxt;
  status_t     fe_r, fe_nxt;

  logic        accept;
  logic [20:0] acc_shift;
  logic [20:0] pt_cp;
  logic [2:0]  pt_len;
  status_t     pt_err;
  logic [20:0] base;
  logic        pt_fire;
  status_t     err_code;
  logic        clear_fe;
  entry_t      ent;

  function automatic status_t classify(input logic [20:0] cp, input logic [2:0] len);
    status_t s;
    s = ST_OK;
    if ((cp < 21'h80 && len != 3'd1) ||
        (cp >= 21'h80 && cp < 21'h800 && len != 3'd2) ||
        (cp >= 21'h800 && cp <= BmpMax && len != 3'd3)) begin
      s = ST_OVERLONG;
    end else if (cp > CpMax || (cp >= SurrFirst && cp <= SurrLast)) begin
      s = ST_BAD_POINT;
    end
    return s;
  endfunction

  function automatic result_t unit_res(input logic [15:0] u, input logic bo);
    result_t r;
    r.code_unit   = bo ? u : {u[7:0], u[15:8]};
    r.unit_valid  = 1'b1;
    r.string_done = 1'b0;
    r.status      = ST_OK;
    return r;
  endfunction

  function automatic result_t end_res(input status_t s);
    result_t r;
    r.code_unit   = '0;
    r.unit_valid  = 1'b0;
    r.string_done = 1'b1;
    r.status      = s;
    return r;
  endfunction

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign acc_shift = {acc_r[14:0], in_byte[5:0]};
  assign pt_cp     = (bl_r != 2'd0) ? acc_shift : {13'd0, in_byte};
  assign pt_len    = (bl_r != 2'd0) ? len_r : 3'd1;
  assign pt_err    = classify(pt_cp, pt_len);
  assign base      = pt_cp - SuppBase;

  always_comb begin
    bl_nxt   = bl_r;
    len_nxt  = len_r;
    acc_nxt  = acc_r;
    fe_nxt   = fe_r;
    push     = 1'b0;
    pt_fire  = 1'b0;
    err_code = ST_OK;
    clear_fe = 1'b0;
    ent      = '0;
    if (accept) begin
      if (bl_r != 2'd0) begin
        if (in_byte == 8'd0) begin
          // string cut inside a sequence: zero unit, then end of string
          err_code = ST_ENDED_EARLY;
          push     = 1'b1;
          ent.two  = 1'b1;
          ent.r0   = unit_res(16'd0, byte_order);
          ent.r1   = end_res((fe_r != ST_OK) ? fe_r : ST_ENDED_EARLY);
          clear_fe = 1'b1;
          bl_nxt   = '0;
          len_nxt  = '0;
          acc_nxt  = '0;
        end else if (in_byte[7:6] != 2'b10) begin
          err_code = ST_INCOMPLETE;
          push     = 1'b1;
          ent.r0   = unit_res(16'd0, byte_order);
          bl_nxt   = '0;
          len_nxt  = '0;
          acc_nxt  = '0;
        end else begin
          acc_nxt = acc_shift;
          bl_nxt  = bl_r - 2'd1;
          if (bl_r == 2'd1) begin
            pt_fire = 1'b1;
            len_nxt = '0;
            acc_nxt = '0;
          end
        end
      end else begin
        if (in_byte == 8'd0) begin
          push     = 1'b1;
          ent.r0   = end_res(fe_r);
          clear_fe = 1'b1;
        end else if (!in_byte[7]) begin
          pt_fire = 1'b1;
        end else if (in_byte[7:5] == 3'b110) begin
          len_nxt = 3'd2;
          acc_nxt = {16'd0, in_byte[4:0]};
          bl_nxt  = 2'd1;
        end else if (in_byte[7:4] == 4'b1110) begin
          len_nxt = 3'd3;
          acc_nxt = {17'd0, in_byte[3:0]};
          bl_nxt  = 2'd2;
        end else if (in_byte[7:3] == 5'b11110) begin
          len_nxt = 3'd4;
          acc_nxt = {18'd0, in_byte[2:0]};
          bl_nxt  = 2'd3;
        end else begin
          err_code = ST_BAD_LEAD;
          push     = 1'b1;
          ent.r0   = unit_res(16'd0, byte_order);
        end
      end

      if (pt_fire) begin
        push = 1'b1;
        if (pt_err != ST_OK) begin
          err_code = pt_err;
          ent.r0   = unit_res(16'd0, byte_order);
        end else if (pt_cp > BmpMax) begin
          ent.two = 1'b1;
          ent.r0  = unit_res({6'd0, base[19:10]} + HiSurrBase, byte_order);
          ent.r1  = unit_res({6'd0, base[9:0]} + LoSurrBase, byte_order);
        end else begin
          ent.r0 = unit_res(pt_cp[15:0], byte_order);
        end
      end

      if (clear_fe) begin
        fe_nxt = ST_OK;
      end else if (fe_r == ST_OK && err_code != ST_OK) begin
        fe_nxt = err_code;
      end
    end
  end

  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bl_r  <= '0;
      len_r <= '0;
      acc_r <= '0;
      fe_r  <= ST_OK;
    end else begin
      bl_r  <= bl_nxt;
      len_r <= len_nxt;
      acc_r <= acc_nxt;
      fe_r  <= fe_nxt;
    end
  end

  a_len_tracks_left: assert property (@(posedge clk) disable iff (!rst_n)
    (bl_r != 2'd0) |-> (len_r > {1'b0, bl_r}))
    else $error("sequence length out of step with bytes left");

  a_idle_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (bl_r == 2'd0) |-> (len_r == 3'd0 && acc_r == 21'd0))
    else $error("sequence state not cleared between code points");

  a_end_clears_error: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_entry.r0.string_done && !push_entry.two) |=> (fe_r == ST_OK))
    else $error("first error not cleared at end of string");

endmodule

@@ src/u8u16_queue.sv @@
module u8u16_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  u8u16_pkg::entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output u8u16_pkg::entry_t head_entry
);
  import u8u16_pkg::*;

  entry_t           mem_r [QDepth];
  logic [QPtrW-1:0] wr_r, wr_nxt;
  logic [QPtrW-1:0] rd_r, rd_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == QCntW'(QDepth));
  assign head_valid = (cnt_r != '0);
  assign head_entry = mem_r[rd_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_nxt  = do_push ? wr_r + QPtrW'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + QPtrW'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - QCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCntW'(QDepth))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0 && cnt_r != QCntW'(QDepth)) |-> (wr_r != rd_r))
    else $error("queue pointers disagree with count");

endmodule

@@ src/u8u16_back.sv @@
module u8u16_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  u8u16_pkg::entry_t q_entry,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output u8u16_pkg::result_t out_res,
  output logic              out_last
);
  import u8u16_pkg::*;

  logic    phase_r, phase_nxt;
  logic    vld_r, vld_nxt;
  result_t res_r;
  logic    last_r;
  logic    load;
  result_t sel_res;
  logic    sel_last;

  assign load     = q_valid && (!vld_r || out_ready);
  assign sel_res  = phase_r ? q_entry.r1 : q_entry.r0;
  assign sel_last = phase_r || !q_entry.two;
  assign pop      = load && sel_last;

  always_comb begin
    phase_nxt = phase_r;
    vld_nxt   = vld_r;
    if (load) begin
      vld_nxt   = 1'b1;
      phase_nxt = !sel_last;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= sel_res;
      last_r <= sel_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      vld_r   <= vld_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;
  assign out_last  = last_r;

  a_phase_has_pair: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (q_valid && q_entry.two))
    else $error("second half pending without a pair at head");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && res_r.string_done) |-> last_r)
    else $error("end of string result not marked last");

  a_pair_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !phase_r && q_entry.two) |=> phase_r)
    else $error("pair did not move to its second half");

endmodule

@@ src/utf8_to_utf16_transcoder.sv @@
// UTF-8 to UTF-16 transcoder.
// in_if   : one UTF-8 byte per transaction (valid/ready). A zero byte ends the string.
// out_if  : one UTF-16 unit per transaction, first wire byte in code_unit[15:8];
//           the end-of-string transaction has unit_valid=0, string_done=1 and carries
//           the first error of the string in status. last_of_run marks the final
//           transaction caused by an input byte.
// APB port: register 0 (byte address 0) is byte_order, reset 1 (big endian).
//           Write it only while the block is idle.
// Throughput: one input byte per cycle while the queue is not full. A code point
//   above 0xFFFF makes two output transactions; the 4-entry queue between the
//   decode front and the output back absorbs the burst.
// Path: results go into the queue, then into the back's output register.
// Reset: decode state, first-error status, queue and output valid clear;
//   byte_order returns to big endian.
// Output stall: the back holds its result; the queue fills and in_if.ready drops
//   only when all four entries are taken.
module utf8_to_utf16_transcoder (
  input  logic                clk,
  input  logic                rst_n,
  u8u16_byte_if.sink          in_if,
  u8u16_unit_if.source        out_if,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import u8u16_pkg::*;

  logic    bo_r, bo_nxt;
  logic    cfg_wr;

  logic    push;
  entry_t  push_entry;
  logic    q_full;
  logic    q_valid;
  entry_t  q_entry;
  logic    pop;
  result_t out_res;

  // config register; index is the word address
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    bo_nxt = bo_r;
    if (cfg_wr && paddr[2] == RegByteOrder) begin
      bo_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bo_r <= 1'b1;
    end else begin
      bo_r <= bo_nxt;
    end
  end

  assign prdata = (paddr[2] == RegByteOrder) ? {31'd0, bo_r} : 32'd0;

  // front: byte decode, validation, result forming
  u8u16_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_byte    (in_if.utf8_byte),
    .in_ready   (in_if.ready),
    .byte_order (bo_r),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // decouples decode from output stalls and surrogate pairs
  u8u16_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_entry (q_entry)
  );

  // back: splits entries into output transactions
  u8u16_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .pop       (pop),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_res   (out_res),
    .out_last  (out_if.last_of_run)
  );

  assign out_if.code_unit   = out_res.code_unit;
  assign out_if.unit_valid  = out_res.unit_valid;
  assign out_if.string_done = out_res.string_done;
  assign out_if.status      = out_res.status;

endmodule

@@ verif/utf8_to_utf16_transcoder_tb.sv @@
module utf8_to_utf16_transcoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u8u16_pkg::*;

  // Byte address of byte_order: register 0, 4 bytes per register.
  localparam logic [2:0] ByteOrderAddr = {RegByteOrder, 2'b00};
  // Quiet cycles before a register write or the final verdict. A lead byte
  // gives no transaction, so the block can still be busy when the last
  // expected unit has come out.
  localparam int SettleCycles = 12;
  // Cycles the sink refuses units during each forced backpressure window.
  localparam int LongHoldCycles = 120;
  // Random bytes per configuration phase.
  localparam int PhaseBytes = 450;

  // One expected output transaction.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        string_done;
    status_t     status;
    logic        last_of_run;
  } utf16_result_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  u8u16_byte_if byte_ch ();
  u8u16_unit_if unit_ch ();

  utf8_to_utf16_transcoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (byte_ch),
    .out_if  (unit_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Bytes waiting to be sent, and the units the decoder model says must follow.
  logic [7:0]    utf8_q[$];
  utf16_result_t utf16_q[$];

  int err_count;
  int sent_cnt;
  int in_idle_pct;
  int out_idle_pct;
  int in_gap;
  int out_stall;
  logic long_hold;
  utf16_result_t want;

  // Decoder model state: mirror of the register plus the sequence state.
  logic        cfg_big_endian;
  logic [1:0]  pend_left;
  logic [2:0]  seq_len;
  logic [20:0] cp_acc;
  status_t     first_err;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, exp_val);
    err_count++;
  endtask

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_idle(int pct);
    if ($urandom_range(99, 0) >= pct) return 0;
    if ($urandom_range(9, 0) == 0) return $urandom_range(30, 8);
    return $urandom_range(3, 1);
  endfunction

  // Append one byte to the send queue.
  function automatic void add_byte(logic [7:0] b);
    utf8_q = {utf8_q, b};
  endfunction

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  // Queue one unit; little endian swaps the wire bytes of real units only.
  function automatic void expect_unit(logic [15:0] unit, logic uv, logic done,
                                      status_t st, logic last);
    utf16_result_t r;
    r.code_unit   = (!cfg_big_endian && uv) ? {unit[7:0], unit[15:8]} : unit;
    r.unit_valid  = uv;
    r.string_done = done;
    r.status      = st;
    r.last_of_run = last;
    utf16_q = {utf16_q, r};
  endfunction

  // Status is sticky: only the first error of a string survives.
  function automatic void note_error(status_t st);
    if (first_err == ST_OK) first_err = st;
  endfunction

  // A failed sequence gives a single zero unit.
  function automatic void expect_bad_unit(status_t st);
    note_error(st);
    expect_unit(16'h0000, 1'b1, 1'b0, ST_OK, 1'b1);
  endfunction

  // End-of-string transaction, then a clean slate for the next string.
  function automatic void close_string();
    expect_unit(16'h0000, 1'b0, 1'b1, first_err, 1'b1);
    first_err = ST_OK;
    pend_left = '0;
    seq_len   = '0;
    cp_acc    = '0;
  endfunction

  function automatic void expect_code_point(logic [20:0] cp, logic [2:0] len);
    logic [19:0] off;
    logic        overlong;
    overlong = (cp < 21'h80 && len != 3'd1) ||
               (cp >= 21'h80 && cp < 21'h800 && len != 3'd2) ||
               (cp >= 21'h800 && cp <= BmpMax && len != 3'd3);
    if (overlong) begin
      expect_bad_unit(ST_OVERLONG);
    end else if (cp > CpMax || (cp >= SurrFirst && cp <= SurrLast)) begin
      expect_bad_unit(ST_BAD_POINT);
    end else if (cp > BmpMax) begin
      // Supplementary plane: surrogate pair, high half first.
      off = 20'(cp - SuppBase);
      expect_unit(HiSurrBase + 16'(off[19:10]), 1'b1, 1'b0, ST_OK, 1'b0);
      expect_unit(LoSurrBase + 16'(off[9:0]), 1'b1, 1'b0, ST_OK, 1'b1);
    end else begin
      expect_unit(cp[15:0], 1'b1, 1'b0, ST_OK, 1'b1);
    end
  endfunction

  function automatic void transcode_byte(logic [7:0] b);
    logic [20:0] cp;
    logic [2:0]  len;
    if (pend_left != 2'd0) begin
      if (b == 8'h00) begin
        // String ends inside a sequence: zero unit, then the closing transaction.
        note_error(ST_ENDED_EARLY);
        expect_unit(16'h0000, 1'b1, 1'b0, ST_OK, 1'b0);
        close_string();
      end else if (b[7:6] != 2'b10) begin
        // Continuation missing; the byte is swallowed, not taken as a new lead.
        pend_left = '0;
        seq_len   = '0;
        cp_acc    = '0;
        expect_bad_unit(ST_INCOMPLETE);
      end else begin
        cp_acc    = {cp_acc[14:0], b[5:0]};
        pend_left = pend_left - 2'd1;
        if (pend_left == 2'd0) begin
          cp      = cp_acc;
          len     = seq_len;
          seq_len = '0;
          cp_acc  = '0;
          expect_code_point(cp, len);
        end
      end
    end else if (b == 8'h00) begin
      close_string();
    end else if (!b[7]) begin
      expect_code_point({14'd0, b[6:0]}, 3'd1);
    end else if (b[7:5] == 3'b110) begin
      seq_len   = 3'd2;
      cp_acc    = {16'd0, b[4:0]};
      pend_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      seq_len   = 3'd3;
      cp_acc    = {17'd0, b[3:0]};
      pend_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      seq_len   = 3'd4;
      cp_acc    = {18'd0, b[2:0]};
      pend_left = 2'd3;
    end else begin
      // Stray continuation byte or 0xF8..0xFF.
      expect_bad_unit(ST_BAD_LEAD);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  // Encode cp in len bytes (overlong forms allowed) and queue the first keep bytes.
  function automatic void queue_code_point(logic [20:0] cp, int len, int keep);
    logic [7:0] enc[4];
    case (len)
      1: enc[0] = {1'b0, cp[6:0]};
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) add_byte(enc[i]);
  endfunction

  // A legal code point for the given length, range ends favored.
  function automatic logic [20:0] pick_code_point(int len);
    logic [20:0] lo;
    logic [20:0] hi;
    logic [20:0] cp;
    case (len)
      1:       begin lo = 21'h1;     hi = 21'h7F;   end
      2:       begin lo = 21'h80;    hi = 21'h7FF;  end
      3:       begin lo = 21'h800;   hi = BmpMax;   end
      default: begin lo = SuppBase;  hi = CpMax;    end
    endcase
    case ($urandom_range(7, 0))
      0:       cp = lo;
      1:       cp = hi;
      default: cp = 21'($urandom_range(hi, lo));
    endcase
    if (len == 3 && cp >= SurrFirst && cp <= SurrLast) cp = cp - 21'h800;
    return cp;
  endfunction

  // Strings of mostly well-formed text with errors mixed in, each closed by 0x00.
  function automatic void build_random_text(int n_bytes);
    int target;
    int n_cp;
    int len;
    int pick;
    target = utf8_q.size() + n_bytes;
    while (utf8_q.size() < target) begin
      n_cp = $urandom_range(10, 0);
      for (int k = 0; k < n_cp; k++) begin
        pick = $urandom_range(99, 0);
        len  = $urandom_range(4, 1);
        if (pick < 70) begin
          queue_code_point(pick_code_point(len), len, len);
        end else if (pick < 76) begin
          // overlong: value fits a shorter form
          len = $urandom_range(4, 2);
          queue_code_point(pick_code_point($urandom_range(len - 1, 1)), len, len);
        end else if (pick < 80) begin
          queue_code_point(21'($urandom_range(SurrLast, SurrFirst)), 3, 3);
        end else if (pick < 84) begin
          queue_code_point(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4, 4);
        end else if (pick < 90) begin
          // cut short; whatever comes next breaks the sequence
          len = $urandom_range(4, 2);
          queue_code_point(pick_code_point(len), len, $urandom_range(len - 1, 1));
        end else begin
          add_byte(8'($urandom_range(255, 0)));
        end
      end
      add_byte(8'h00);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Byte driver: holds a byte until the transaction completes, random gaps between.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      byte_ch.valid     <= 1'b0;
      byte_ch.utf8_byte <= 8'h00;
      in_gap = 0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        transcode_byte(byte_ch.utf8_byte);
        void'(utf8_q.pop_front());
        sent_cnt++;
      end
      if (!(byte_ch.valid && !byte_ch.ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          byte_ch.valid <= 1'b0;
        end else if (utf8_q.size() != 0) begin
          byte_ch.valid     <= 1'b1;
          byte_ch.utf8_byte <= utf8_q[0];
          in_gap = pick_idle(in_idle_pct);
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Unit monitor: checks every transaction against the oldest expectation and
  // throttles ready.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      unit_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (unit_ch.valid && unit_ch.ready) begin
        if (utf16_q.size() == 0) begin
          report_mismatch("unexpected transaction, code_unit", 32'(unit_ch.code_unit), 0);
        end else begin
          want = utf16_q.pop_front();
          if (unit_ch.code_unit !== want.code_unit)
            report_mismatch("code_unit", 32'(unit_ch.code_unit), 32'(want.code_unit));
          if (unit_ch.unit_valid !== want.unit_valid)
            report_mismatch("unit_valid", 32'(unit_ch.unit_valid), 32'(want.unit_valid));
          if (unit_ch.string_done !== want.string_done)
            report_mismatch("string_done", 32'(unit_ch.string_done), 32'(want.string_done));
          if (unit_ch.status !== want.status)
            report_mismatch("status", 32'(unit_ch.status), 32'(want.status));
          if (unit_ch.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", 32'(unit_ch.last_of_run), 32'(want.last_of_run));
        end
      end
      if (long_hold) begin
        unit_ch.ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        unit_ch.ready <= 1'b0;
      end else begin
        unit_ch.ready <= 1'b1;
        out_stall = pick_idle(out_idle_pct);
      end
    end
  end

  // Backpressure windows: the sink stops for a long stretch while bytes keep
  // coming, so the internal queue fills and byte ready must drop.
  initial begin
    long_hold = 1'b0;
    while (sent_cnt < 300) @(posedge clk);
    long_hold <= 1'b1;
    repeat (LongHoldCycles) @(posedge clk);
    long_hold <= 1'b0;
    while (sent_cnt < 1100) @(posedge clk);
    long_hold <= 1'b1;
    repeat (LongHoldCycles) @(posedge clk);
    long_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // APB access; every call starts and ends right after a rising edge.
  // ---------------------------------------------------------------------------
  task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Read back the register and compare with the model's copy.
  task automatic check_byte_order();
    logic [31:0] rd;
    apb_access(1'b0, ByteOrderAddr, '0, rd);
    if (rd !== {31'd0, cfg_big_endian})
      report_mismatch("byte_order readback", rd, {31'd0, cfg_big_endian});
  endtask

  task automatic set_byte_order(logic big);
    logic [31:0] rd;
    apb_access(1'b1, ByteOrderAddr, {31'd0, big}, rd);
    cfg_big_endian = big;
    check_byte_order();
  endtask

  // Block is idle once every byte went in and every unit came out.
  task automatic drain();
    while (utf8_q.size() != 0 || utf16_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] directed [27];

    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    err_count         = 0;
    sent_cnt          = 0;
    in_idle_pct       = 0;
    out_idle_pct      = 0;
    // model state after reset: big endian, no open sequence, no error
    cfg_big_endian    = 1'b1;
    pend_left         = '0;
    seq_len           = '0;
    cp_acc            = '0;
    first_err         = ST_OK;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_byte_order();

    // Directed strings, back to back, reset byte order:
    //   ASCII, first supplementary point (pair), close clean;
    //   U+10FFFF, stray continuation, 0xFF lead;
    //   overlong 0xC0 lead, sequence broken by ASCII;
    //   encoded surrogate, 0xF5 lead beyond U+10FFFF;
    //   string ending inside a sequence.
    directed = '{8'h41, 8'hF0, 8'h90, 8'h80, 8'h80, 8'h00,
                 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h80, 8'hFF, 8'h00,
                 8'hC0, 8'h80, 8'hE2, 8'h41, 8'h00,
                 8'hED, 8'hA0, 8'h80, 8'hF5, 8'h80, 8'h80, 8'h80, 8'h00,
                 8'hE0};
    foreach (directed[i]) add_byte(directed[i]);
    add_byte(8'h00);
    drain();

    // Random phases alternate byte order; idle mix varies per phase.
    for (int ph = 0; ph < 4; ph++) begin
      set_byte_order(ph[0]);
      case (ph)
        0:       begin in_idle_pct <= 20; out_idle_pct <= 20; end
        1:       begin in_idle_pct <= 40; out_idle_pct <= 10; end
        2:       begin in_idle_pct <= 10; out_idle_pct <= 50; end
        default: begin in_idle_pct <= 0;  out_idle_pct <= 0;  end
      endcase
      build_random_text(PhaseBytes);
      drain();
    end

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
